// ===== rtl/psq_pkg.sv =====
// ----------------------------------------------------------------------------
// psq_pkg
// Types and constants shared by the packet slot queue.
// ----------------------------------------------------------------------------
package psq_pkg;

  localparam int SLOTS        = 16;
  localparam int PACKET_BYTES = 62;
  localparam int FRAME_BYTES  = 64;
  localparam int SLOT_W       = 4;
  localparam int POS_W        = 6;
  localparam int ADDR_W       = SLOT_W + POS_W;
  localparam int HYST_GAP     = 10;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_QUEUED  = 2'd1,
    SLOT_SENDING = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_ERR    = 2'd1,
    STAT_NOCONN = 2'd2
  } stat_code_t;

  typedef enum logic [1:0] {
    REG_QUEUE_EN  = 2'd0,
    REG_SLOTS     = 2'd1,
    REG_WARN_LVL  = 2'd2,
    REG_STATS_WIN = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR0,
    S_HDR1,
    S_SCAN,
    S_SEND
  } state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] sender_id;
    logic [7:0] packet_length;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       link_running;
    logic       transmitter_idle;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  status;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        overflow;
    logic [4:0]  pending_count;
    logic [4:0]  peak_count;
    logic [15:0] lost_count;
    logic        warning_raised;
  } out_word_t;

endpackage

// ===== rtl/psq_ram.sv =====
// ----------------------------------------------------------------------------
// psq_ram
// Single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module psq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/packet_slot_queue_with_header.sv =====
// ----------------------------------------------------------------------------
// packet_slot_queue_with_header
// Ring of packet slots in a byte RAM; stores framed packets, sends on poll.
// ----------------------------------------------------------------------------
// Store word: a first byte that opens a packet holds busy in S_HDR0, S_HDR1
//   for the header writes. Status word in the cycle after its store word.
// Service poll: scans slots in ring order (up to the ring length), then reads
//   each frame byte via the single RAM port; the first byte passes S_SEND,
//   RAM read and output registers. The receiver cannot stall the word stream.
// Synchronous active-low reset: all slots free, counters zero, no RAM clear.
module packet_slot_queue_with_header (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  psq_pkg::in_word_t   in_data,
  output logic                out_valid,
  output psq_pkg::out_word_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  psq_pkg::state_t   state_r, state_nxt;
  psq_pkg::slot_st_t status_r [psq_pkg::SLOTS];
  psq_pkg::slot_st_t status_nxt [psq_pkg::SLOTS];

  logic        q_en_r;
  logic [4:0]  slots_r, warn_lvl_r;
  logic [15:0] win_r;

  logic [3:0]  store_idx_r, store_idx_nxt, read_idx_r, read_idx_nxt;
  logic [4:0]  pending_r, pending_nxt, peak_r, peak_nxt;
  logic [15:0] win_cnt_r, win_cnt_nxt, lost_r, lost_nxt;
  logic        ovf_r, ovf_nxt;
  logic [4:0]  warn_latch_r, warn_latch_nxt;
  logic [5:0]  wpos_r, wpos_nxt, cur_len_r, cur_len_nxt;
  logic        collect_r, collect_nxt;
  logic [3:0]  hdr_slot_r, hdr_slot_nxt;
  logic [7:0]  hdr_sid_r, hdr_sid_nxt;
  logic [3:0]  scan_i_r, scan_i_nxt, snd_slot_r, snd_slot_nxt;
  logic [4:0]  scan_cnt_r, scan_cnt_nxt;
  logic [6:0]  k_r, k_nxt, len_r, len_nxt, rd_k_r;
  logic        rd_v_r, rd_v_nxt;
  logic        out_valid_r, out_valid_nxt;
  psq_pkg::out_word_t out_r, out_nxt;

  logic                       mem_we;
  logic [psq_pkg::ADDR_W-1:0] mem_addr;
  logic [7:0]                 mem_wd, mem_rd;

  logic [4:0] ring_n;
  logic       snd_last;

  psq_ram #(.DEPTH(psq_pkg::SLOTS * psq_pkg::FRAME_BYTES), .WIDTH(8)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wd),
    .rdata (mem_rd)
  );

  always_comb begin
    if (slots_r == 5'd0) begin
      ring_n = 5'd1;
    end else if (slots_r > 5'(psq_pkg::SLOTS)) begin
      ring_n = 5'(psq_pkg::SLOTS);
    end else begin
      ring_n = slots_r;
    end
  end

  assign busy     = (state_r != psq_pkg::S_IDLE);
  assign snd_last = rd_v_r && (rd_k_r >= 7'd2) && ((rd_k_r + 7'd1) == len_r);

  always_comb begin
    logic       go, commit, emit_st, warn;
    logic [5:0] want, wbase;
    logic [4:0] p1, nxt_i, si1;
    logic [15:0] wc1;
    psq_pkg::stat_code_t code;

    state_nxt      = state_r;
    status_nxt     = status_r;
    store_idx_nxt  = store_idx_r;
    read_idx_nxt   = read_idx_r;
    pending_nxt    = pending_r;
    peak_nxt       = peak_r;
    win_cnt_nxt    = win_cnt_r;
    lost_nxt       = lost_r;
    ovf_nxt        = ovf_r;
    warn_latch_nxt = warn_latch_r;
    wpos_nxt       = wpos_r;
    cur_len_nxt    = cur_len_r;
    collect_nxt    = collect_r;
    hdr_slot_nxt   = hdr_slot_r;
    hdr_sid_nxt    = hdr_sid_r;
    scan_i_nxt     = scan_i_r;
    scan_cnt_nxt   = scan_cnt_r;
    snd_slot_nxt   = snd_slot_r;
    k_nxt          = k_r;
    len_nxt        = len_r;
    rd_v_nxt       = 1'b0;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    mem_we         = 1'b0;
    mem_addr       = {snd_slot_r, k_r[psq_pkg::POS_W-1:0]};
    mem_wd         = in_data.data_byte;
    go      = 1'b0;
    commit  = 1'b0;
    emit_st = 1'b0;
    warn    = 1'b0;
    code    = psq_pkg::STAT_OK;
    want    = cur_len_r;
    wbase   = wpos_r;
    p1      = 5'd0;
    nxt_i   = 5'd0;
    si1     = 5'd0;
    wc1     = 16'd0;

    case (state_r)
      psq_pkg::S_IDLE: begin
        if (start && !in_data.kind) begin
          if (in_data.first_of_packet) begin
            collect_nxt = 1'b0;
            if (!in_data.link_running) begin
              emit_st = 1'b1;
              code    = psq_pkg::STAT_NOCONN;
            end else if (status_r[store_idx_r] != psq_pkg::SLOT_FREE) begin
              if (lost_r != 16'hFFFF) lost_nxt = lost_r + 16'd1;
              ovf_nxt = 1'b1;
              emit_st = 1'b1;
              code    = psq_pkg::STAT_ERR;
            end else if (in_data.packet_length == 8'd0 ||
                         in_data.packet_length > 8'(psq_pkg::PACKET_BYTES)) begin
              emit_st = 1'b1;
              code    = psq_pkg::STAT_ERR;
            end else begin
              go           = 1'b1;
              want         = in_data.packet_length[5:0];
              wbase        = 6'd0;
              cur_len_nxt  = in_data.packet_length[5:0];
              hdr_slot_nxt = store_idx_r;
              hdr_sid_nxt  = in_data.sender_id;
              collect_nxt  = 1'b1;
              state_nxt    = psq_pkg::S_HDR0;
            end
          end else begin
            go = collect_r;
          end
          if (go) begin
            if (wbase < want) begin
              mem_we   = 1'b1;
              mem_addr = {store_idx_r, wbase + 6'd2};
              wbase    = wbase + 6'd1;
            end
            wpos_nxt = wbase;
            if (in_data.last_of_packet) begin
              collect_nxt = 1'b0;
              emit_st     = 1'b1;
              if (wbase < want) begin
                code = psq_pkg::STAT_ERR;
              end else begin
                commit = 1'b1;
              end
            end
          end
          if (commit) begin
            status_nxt[store_idx_r] = psq_pkg::SLOT_QUEUED;
            p1  = (pending_r == 5'd31) ? pending_r : pending_r + 5'd1;
            pending_nxt = p1;
            wc1 = win_cnt_r + 16'd1;
            if (wc1 >= win_r) begin
              peak_nxt    = p1;
              win_cnt_nxt = 16'd0;
            end else begin
              win_cnt_nxt = wc1;
              if (peak_r < p1) peak_nxt = p1;
            end
            si1 = {1'b0, store_idx_r} + 5'd1;
            store_idx_nxt = (si1 >= ring_n) ? 4'd0 : si1[3:0];
            if (p1 > warn_lvl_r) begin
              if (warn_latch_r == 5'd0) begin
                warn_latch_nxt = p1;
                warn           = 1'b1;
              end
            end else if ({1'b0, p1} + 6'(psq_pkg::HYST_GAP) < {1'b0, warn_lvl_r}) begin
              warn_latch_nxt = 5'd0;
            end
          end
        end else if (start && in_data.kind) begin
          if (q_en_r && in_data.link_running && in_data.transmitter_idle) begin
            if (status_r[read_idx_r] == psq_pkg::SLOT_SENDING) begin
              status_nxt[read_idx_r] = psq_pkg::SLOT_FREE;
            end
            scan_i_nxt   = read_idx_r;
            scan_cnt_nxt = 5'd0;
            state_nxt    = psq_pkg::S_SCAN;
          end
        end
      end
      psq_pkg::S_HDR0: begin
        mem_we    = 1'b1;
        mem_addr  = {hdr_slot_r, 6'd0};
        mem_wd    = hdr_sid_r;
        state_nxt = psq_pkg::S_HDR1;
      end
      psq_pkg::S_HDR1: begin
        mem_we    = 1'b1;
        mem_addr  = {hdr_slot_r, 6'd1};
        mem_wd    = {2'b00, cur_len_r} + 8'd2;
        state_nxt = psq_pkg::S_IDLE;
      end
      psq_pkg::S_SCAN: begin
        nxt_i = {1'b0, scan_i_r} + 5'd1;
        if (nxt_i >= ring_n) nxt_i = 5'd0;
        scan_i_nxt = nxt_i[3:0];
        if (status_r[nxt_i[3:0]] == psq_pkg::SLOT_QUEUED) begin
          status_nxt[nxt_i[3:0]] = psq_pkg::SLOT_SENDING;
          read_idx_nxt = nxt_i[3:0];
          snd_slot_nxt = nxt_i[3:0];
          if (pending_r != 5'd0) pending_nxt = pending_r - 5'd1;
          k_nxt     = 7'd0;
          state_nxt = psq_pkg::S_SEND;
        end else begin
          scan_cnt_nxt = scan_cnt_r + 5'd1;
          if (scan_cnt_r + 5'd1 == ring_n) state_nxt = psq_pkg::S_IDLE;
        end
      end
      psq_pkg::S_SEND: begin
        // len comes back with header byte one; it is at least three
        if (k_r < 7'd3 || k_r < len_r) begin
          rd_v_nxt = 1'b1;
          k_nxt    = k_r + 7'd1;
        end
        if (rd_v_r) begin
          if (rd_k_r == 7'd1) len_nxt = mem_rd[6:0];
          out_valid_nxt = 1'b1;
          out_nxt = '{result_kind: 1'b1, status: psq_pkg::STAT_OK, out_byte: mem_rd,
                      out_last: snd_last, overflow: ovf_r, pending_count: pending_r,
                      peak_count: peak_r, lost_count: lost_r, warning_raised: 1'b0};
          if (snd_last) begin
            state_nxt = psq_pkg::S_IDLE;
            rd_v_nxt  = 1'b0;
          end
        end
      end
      default: state_nxt = psq_pkg::S_IDLE;
    endcase

    if (emit_st) begin
      out_valid_nxt = 1'b1;
      out_nxt = '{result_kind: 1'b0, status: code, out_byte: 8'd0, out_last: 1'b0,
                  overflow: ovf_nxt, pending_count: pending_nxt, peak_count: peak_nxt,
                  lost_count: lost_nxt, warning_raised: warn};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= psq_pkg::S_IDLE;
      status_r     <= '{default: psq_pkg::SLOT_FREE};
      q_en_r       <= 1'b1;
      slots_r      <= 5'd16;
      warn_lvl_r   <= 5'd12;
      win_r        <= 16'd100;
      store_idx_r  <= 4'd0;
      read_idx_r   <= 4'(psq_pkg::SLOTS - 1);
      pending_r    <= 5'd0;
      peak_r       <= 5'd0;
      win_cnt_r    <= 16'd0;
      lost_r       <= 16'd0;
      ovf_r        <= 1'b0;
      warn_latch_r <= 5'd0;
      wpos_r       <= 6'd0;
      collect_r    <= 1'b0;
      rd_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      status_r     <= status_nxt;
      store_idx_r  <= store_idx_nxt;
      read_idx_r   <= read_idx_nxt;
      pending_r    <= pending_nxt;
      peak_r       <= peak_nxt;
      win_cnt_r    <= win_cnt_nxt;
      lost_r       <= lost_nxt;
      ovf_r        <= ovf_nxt;
      warn_latch_r <= warn_latch_nxt;
      wpos_r       <= wpos_nxt;
      collect_r    <= collect_nxt;
      rd_v_r       <= rd_v_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          psq_pkg::REG_QUEUE_EN:  q_en_r     <= cfg_data[0];
          psq_pkg::REG_SLOTS:     slots_r    <= cfg_data[4:0];
          psq_pkg::REG_WARN_LVL:  warn_lvl_r <= cfg_data[4:0];
          psq_pkg::REG_STATS_WIN: win_r      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_len_r  <= cur_len_nxt;
    hdr_slot_r <= hdr_slot_nxt;
    hdr_sid_r  <= hdr_sid_nxt;
    scan_i_r   <= scan_i_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    snd_slot_r <= snd_slot_nxt;
    k_r        <= k_nxt;
    len_r      <= len_nxt;
    rd_k_r     <= k_r;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_hdr_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == psq_pkg::S_HDR0 |=> state_r == psq_pkg::S_HDR1)
    else $error("header write sequence broken");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psq_pkg::S_SEND && snd_last) |=> state_r == psq_pkg::S_IDLE && out_valid)
    else $error("send did not end on last byte");

  a_pending_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 5'(psq_pkg::SLOTS))
    else $error("pending above slot count");

  a_no_ram_write_send: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psq_pkg::S_SEND || state_r == psq_pkg::S_SCAN) |-> !mem_we)
    else $error("RAM write during service");

endmodule
